### rtl/perceptron_predict_and_train_defines.svh
// Assertion macros shared by the perceptron checker.
`ifndef PERCEPTRON_PREDICT_AND_TRAIN_DEFINES_SVH
`define PERCEPTRON_PREDICT_AND_TRAIN_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PPT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("perceptron check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PPT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("perceptron check failed");

`endif

### rtl/ppt_pkg.sv
// Package: widths, register indexes, error codes and control structs of the perceptron.
`timescale 1ns / 1ps
`default_nettype none
package ppt_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int LR_W       = 12;
  localparam int CNT_CFG_W  = 4;
  localparam int WEIGHT_W   = 32;
  localparam int ERR_W      = 2;
  localparam int FEAT_FRAC  = 12;
  localparam int NUM_INPUTS = 8;

  localparam logic [LR_W-1:0]      LR_RESET = LR_W'(1638);
  localparam logic [CNT_CFG_W-1:0] IU_RESET = CNT_CFG_W'(2);

  localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARNING_RATE = 4'd0,
    REG_INPUTS_USED   = 4'd1
  } cfg_reg_e;

  // Error codes on train_error
  localparam logic [ERR_W-1:0] ERR_ZERO    = 2'b00;
  localparam logic [ERR_W-1:0] ERR_INVALID = 2'b10;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic mac_en;
    logic upd_en;
    logic sel_bias;
    logic pred_load;
    logic out_load;
  } ppt_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_upd;
  } ppt_sts_t;

endpackage
`default_nettype wire

### rtl/ppt_ifs.sv
// Interfaces: input item channel, result channel and configuration write channel.
`timescale 1ns / 1ps
`default_nettype none
interface ppt_in_if #(
  parameter int FEATURE_BITS = 16
) ();
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic                           target;
  logic signed [FEATURE_BITS-1:0] feature_0;
  logic signed [FEATURE_BITS-1:0] feature_1;
  logic signed [FEATURE_BITS-1:0] feature_2;
  logic signed [FEATURE_BITS-1:0] feature_3;
  logic signed [FEATURE_BITS-1:0] feature_4;
  logic signed [FEATURE_BITS-1:0] feature_5;
  logic signed [FEATURE_BITS-1:0] feature_6;
  logic signed [FEATURE_BITS-1:0] feature_7;

  modport source (
    output valid, req_type, target, feature_0, feature_1, feature_2, feature_3,
           feature_4, feature_5, feature_6, feature_7,
    input  ready
  );
  modport sink (
    input  valid, req_type, target, feature_0, feature_1, feature_2, feature_3,
           feature_4, feature_5, feature_6, feature_7,
    output ready
  );
endinterface

interface ppt_out_if import ppt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    prediction;
  logic signed [ERR_W-1:0] train_error;
  logic                    saturated;

  modport source (output valid, prediction, train_error, saturated, input ready);
  modport sink (input valid, prediction, train_error, saturated, output ready);
endinterface

interface ppt_cfg_if import ppt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/ppt_ctrl.sv
// Controller: sequences the multiply-accumulate pass, the update pass and the result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module ppt_ctrl import ppt_pkg::*; #(
  parameter int MAX_FEATURES = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  logic [$clog2(MAX_FEATURES+1)-1:0]   count_i,
  input  ppt_sts_t                            sts_i,
  output ppt_cmd_t                            cmd_o,
  output logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] idx_o
);

  localparam int CNT_W = $clog2(MAX_FEATURES + 1);
  localparam int IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_PRED = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_UWB  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    cmd_o        = '0;
    cmd_o.sel_bias = (idx_q == cnt_q);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cnt_d         = count_i;
          idx_d         = '0;
          state_d       = S_MAC;
        end
      end
      S_MAC: begin
        cmd_o.mac_en = 1'b1;
        if (idx_q == cnt_q) begin
          state_d = S_SUM;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      S_SUM: begin
        state_d = S_PRED;
      end
      S_PRED: begin
        cmd_o.pred_load = 1'b1;
        idx_d           = '0;
        state_d         = sts_i.need_upd ? S_UPD : S_OUT;
      end
      S_UPD: begin
        cmd_o.upd_en = 1'b1;
        if (idx_q == cnt_q) begin
          state_d = S_UWB;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      S_UWB: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the result word until the sink takes it
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign idx_o       = idx_q[IDX_W-1:0];

endmodule
`default_nettype wire

### rtl/ppt_dpath.sv
// Datapath: weight store, shared multiplier, accumulator, saturating update and result register.
`timescale 1ns / 1ps
`default_nettype none
module ppt_dpath import ppt_pkg::*; #(
  parameter int MAX_FEATURES = 8,
  parameter int FEATURE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ppt_cmd_t                            cmd_i,
  input  logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] idx_i,
  input  logic [LR_W-1:0]                     eta_i,
  input  logic                                req_type_i,
  input  logic                                target_i,
  input  logic signed [FEATURE_BITS-1:0]      feat_i [NUM_INPUTS],
  output ppt_sts_t                            sts_o,
  output logic                                pred_o,
  output logic signed [ERR_W-1:0]             err_o,
  output logic                                sat_o
);

  localparam int IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  // Operand b must hold the bias scale 2^FEAT_FRAC as a signed value
  localparam int OPW   = (FEATURE_BITS > FEAT_FRAC + 1) ? FEATURE_BITS : FEAT_FRAC + 2;
  localparam int PW    = WEIGHT_W + OPW;
  localparam int ACC_W = PW + 4;
  localparam int SUM_W = PW + 2;

  localparam logic signed [OPW-1:0] BIAS_SCALE = OPW'(1 << FEAT_FRAC);

  logic signed [FEATURE_BITS-1:0] feat_q [MAX_FEATURES];
  logic                           train_q;
  logic                           target_q;
  logic signed [WEIGHT_W-1:0]     w_q [MAX_FEATURES];
  logic signed [WEIGHT_W-1:0]     bias_q;

  logic signed [WEIGHT_W-1:0]     op_a;
  logic signed [OPW-1:0]          op_b;
  logic signed [WEIGHT_W-1:0]     base_d;
  logic signed [PW-1:0]           prod_d;

  logic signed [PW-1:0]           prod_q;
  logic signed [WEIGHT_W-1:0]     base_q;
  logic                           prod_vld_q;
  logic                           prod_upd_q;
  logic                           prod_bias_q;
  logic [IDX_W-1:0]               prod_idx_q;

  logic signed [ACC_W-1:0]        acc_q;
  logic                           pred_now;
  logic signed [ERR_W-1:0]        err_now;
  logic                           pred_q;
  logic signed [ERR_W-1:0]        err_q;
  logic                           sat_q;

  logic signed [SUM_W-1:0]        step;
  logic signed [SUM_W-1:0]        sum;
  logic signed [WEIGHT_W-1:0]     new_w;
  logic                           clip;

  logic                           out_pred_q;
  logic signed [ERR_W-1:0]        out_err_q;
  logic                           out_sat_q;

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int i = 0; i < MAX_FEATURES; i++) begin
        feat_q[i] <= feat_i[i];
      end
      train_q  <= req_type_i;
      target_q <= target_i;
    end
  end

  // Select multiplier operands: weight or bias, or eta on update, times feature or bias scale
  always_comb begin
    base_d = cmd_i.sel_bias ? bias_q : w_q[idx_i];
    op_b   = cmd_i.sel_bias ? BIAS_SCALE : OPW'(feat_q[idx_i]);
    if (cmd_i.upd_en) begin
      op_a = signed'({{(WEIGHT_W-LR_W){1'b0}}, eta_i});
    end else begin
      op_a = base_d;
    end
    prod_d = PW'(op_a) * PW'(op_b);
  end

  // Product register
  always_ff @(posedge clk_i) begin
    prod_q      <= prod_d;
    base_q      <= base_d;
    prod_upd_q  <= cmd_i.upd_en;
    prod_bias_q <= cmd_i.sel_bias;
    prod_idx_q  <= idx_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mac_en | cmd_i.upd_en;
    end
  end

  // Accumulate the weighted sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      acc_q <= '0;
    end else if (prod_vld_q && !prod_upd_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Decide the class and the error
  always_comb begin
    pred_now        = ~acc_q[ACC_W-1];
    err_now         = train_q ? (ERR_W'({1'b0, target_q}) - ERR_W'({1'b0, pred_now})) : ERR_ZERO;
    sts_o.need_upd  = train_q && (target_q != pred_now);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pred_load) begin
      pred_q <= pred_now;
      err_q  <= err_now;
    end
  end

  // Apply the error sign and saturate the new weight
  always_comb begin
    step = SUM_W'(prod_q);
    if (err_q[ERR_W-1]) begin
      step = -step;
    end
    sum  = SUM_W'(base_q) + step;
    clip = 1'b0;
    priority if (sum > SUM_W'(W_MAX)) begin
      new_w = W_MAX;
      clip  = 1'b1;
    end else if (sum < SUM_W'(W_MIN)) begin
      new_w = W_MIN;
      clip  = 1'b1;
    end else begin
      new_w = sum[WEIGHT_W-1:0];
    end
  end

  // Write back weights and bias
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_FEATURES; i++) begin
        w_q[i] <= '0;
      end
      bias_q <= '0;
    end else if (prod_vld_q && prod_upd_q) begin
      if (prod_bias_q) begin
        bias_q <= new_w;
      end else begin
        w_q[prod_idx_q] <= new_w;
      end
    end
  end

  // Sticky clip flag for the current item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sat_q <= 1'b0;
    end else if (prod_vld_q && prod_upd_q && clip) begin
      sat_q <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_pred_q <= pred_q;
      out_err_q  <= err_q;
      out_sat_q  <= sat_q;
    end
  end

  assign pred_o = out_pred_q;
  assign err_o  = out_err_q;
  assign sat_o  = out_sat_q;

endmodule
`default_nettype wire

### rtl/perceptron_predict_and_train.sv
// Single-layer fixed-point perceptron: predicts a class per item and trains on request.
// Each item takes one multiply per used feature plus one for the bias through a single
// shared 32-bit multiplier, with n = min(inputs_used, MAX_FEATURES) features used. A
// predict item, or a train item that is already classified right, raises its result
// after that pass, and the next word is accepted only once that result is loaded. A
// train item that misclassifies runs a second pass over the same multiplier before its
// result is raised and the next word is taken. A result that still waits in the output
// register holds the block before the hand-off for as long as the sink stalls; once it
// is taken the next word is accepted while the new result waits. Weights and bias are
// signed Q7.24 and reset to zero; the user must write configuration only while the
// block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none
module perceptron_predict_and_train import ppt_pkg::*; #(
  parameter int MAX_FEATURES = 8,
  parameter int FEATURE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppt_cfg_if.sink    cfg_i,
  ppt_in_if.sink     item_i,
  ppt_out_if.source  result_o
);

  localparam int CNT_W = $clog2(MAX_FEATURES + 1);
  localparam int IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

  logic [LR_W-1:0]                lr_q;
  logic [CNT_CFG_W-1:0]           iu_q;
  logic [CNT_W-1:0]               count;
  logic signed [FEATURE_BITS-1:0] feat [NUM_INPUTS];
  ppt_cmd_t                       cmd;
  ppt_sts_t                       sts;
  logic [IDX_W-1:0]               idx;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= LR_RESET;
      iu_q <= IU_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_LEARNING_RATE) begin
        lr_q <= cfg_i.data[LR_W-1:0];
      end else if (cfg_i.index == REG_INPUTS_USED) begin
        iu_q <= cfg_i.data[CNT_CFG_W-1:0];
      end
    end
  end

  // Clamp the feature count to the weight store
  assign count = (iu_q > CNT_CFG_W'(MAX_FEATURES)) ? CNT_W'(MAX_FEATURES) : CNT_W'(iu_q);

  assign feat[0] = item_i.feature_0;
  assign feat[1] = item_i.feature_1;
  assign feat[2] = item_i.feature_2;
  assign feat[3] = item_i.feature_3;
  assign feat[4] = item_i.feature_4;
  assign feat[5] = item_i.feature_5;
  assign feat[6] = item_i.feature_6;
  assign feat[7] = item_i.feature_7;

  ppt_ctrl #(
    .MAX_FEATURES (MAX_FEATURES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .count_i     (count),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .idx_o       (idx)
  );

  ppt_dpath #(
    .MAX_FEATURES (MAX_FEATURES),
    .FEATURE_BITS (FEATURE_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .idx_i      (idx),
    .eta_i      (lr_q),
    .req_type_i (item_i.req_type),
    .target_i   (item_i.target),
    .feat_i     (feat),
    .sts_o      (sts),
    .pred_o     (result_o.prediction),
    .err_o      (result_o.train_error),
    .sat_o      (result_o.saturated)
  );

endmodule
`default_nettype wire

### rtl/ppt_checker.sv
// Port-level checker for the perceptron and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "perceptron_predict_and_train_defines.svh"
module ppt_checker import ppt_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic             prediction_i,
  input wire logic [ERR_W-1:0] train_error_i,
  input wire logic             saturated_i
);

  // A stalled result word holds
  `PPT_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(prediction_i) && $stable(train_error_i) && $stable(saturated_i))

  // One item at a time: acceptance closes the input side
  `PPT_ASSERT_NXT(a_one_item, in_valid_i && in_ready_i, !in_ready_i)

  // The error is one of -1, 0, 1 and agrees with the prediction
  `PPT_ASSERT_IMP(a_err_code, out_valid_i, train_error_i != ERR_INVALID)
  `PPT_ASSERT_IMP(a_err_pred, out_valid_i && (train_error_i != ERR_ZERO),
    prediction_i == train_error_i[ERR_W-1])

  // Clipping only happens on an update
  `PPT_ASSERT_IMP(a_sat_upd, out_valid_i && saturated_i, train_error_i != ERR_ZERO)

endmodule

bind perceptron_predict_and_train ppt_checker u_ppt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_i.valid),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .prediction_i  (result_o.prediction),
  .train_error_i (result_o.train_error),
  .saturated_i   (result_o.saturated)
);
`default_nettype wire

### sim/perceptron_predict_and_train_test.sv
// Self-checking testbench for the perceptron: directed table, random phases, saturation drive.
`timescale 1ns / 1ps
module perceptron_predict_and_train_test;
  import ppt_pkg::*;

  localparam int MAX_FEAT   = 8;
  localparam int FEAT_BITS  = 16;
  localparam int TIMEOUT_NS = 2_000_000;

  localparam logic [FEAT_BITS-1:0] FEAT_MAX = {1'b0, {(FEAT_BITS-1){1'b1}}};
  localparam logic [FEAT_BITS-1:0] FEAT_MIN = {1'b1, {(FEAT_BITS-1){1'b0}}};
  localparam logic [FEAT_BITS-1:0] FEAT_ZERO = '0;

  localparam logic REQ_PREDICT = 1'b0;
  localparam logic REQ_TRAIN   = 1'b1;

  localparam logic [ERR_W-1:0] ERR_NEG = 2'b11;
  localparam logic [ERR_W-1:0] ERR_POS = 2'b01;

  typedef struct packed {
    logic                                  req_type;
    logic                                  target;
    logic [NUM_INPUTS-1:0][FEAT_BITS-1:0]  feat;
  } item_word_t;

  typedef struct packed {
    logic             prediction;
    logic [ERR_W-1:0] train_error;
    logic             saturated;
  } verdict_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;
    item_word_t            item;
    logic                  typed;
    verdict_t              want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  ppt_in_if #(.FEATURE_BITS(FEAT_BITS)) item_ch ();
  ppt_out_if                            result_ch ();
  ppt_cfg_if                            cfg_ch ();

  perceptron_predict_and_train #(
    .MAX_FEATURES(MAX_FEAT),
    .FEATURE_BITS(FEAT_BITS)
  ) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_ch),
    .item_i   (item_ch),
    .result_o (result_ch)
  );

  // Mirror of the learned state and the registers
  int weight_model [MAX_FEAT];
  int bias_model;
  int rate_model;
  int count_model;

  verdict_t  pending_verdicts [$];
  stim_row_t directed_rows [$];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int items_sent;
  int trains_sent;
  int verdicts_seen;
  int clips_seen;
  int writes_done;

  initial begin
    clk_i = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  // Add with clipping at the signed 32-bit limits
  function automatic int clip_add(int base, longint delta, output logic hit);
    longint sumv;
    sumv = longint'(base) + delta;
    hit  = 1'b0;
    if (sumv > longint'(W_MAX)) begin
      hit = 1'b1;
      return int'(W_MAX);
    end
    if (sumv < longint'(W_MIN)) begin
      hit = 1'b1;
      return int'(W_MIN);
    end
    return int'(sumv);
  endfunction

  // Classify one word and, on a train request, apply the learning rule
  function automatic verdict_t classify_and_learn(item_word_t w);
    verdict_t v;
    longint   acc;
    longint   scaled;
    int       n;
    int       k;
    int       e;
    logic     hit;
    logic     clip;
    n    = (count_model > MAX_FEAT) ? MAX_FEAT : count_model;
    acc  = longint'(bias_model) <<< FEAT_FRAC;
    for (k = 0; k < n; k++) begin
      acc += longint'(weight_model[k]) * longint'($signed(w.feat[k]));
    end
    v.prediction = (acc >= 0);
    e    = 0;
    clip = 1'b0;
    if (w.req_type == REQ_TRAIN) begin
      e = int'(w.target) - int'(v.prediction);
      if (e != 0) begin
        scaled = longint'(e) * longint'(rate_model);
        for (k = 0; k < n; k++) begin
          weight_model[k] = clip_add(weight_model[k], scaled * longint'($signed(w.feat[k])), hit);
          clip |= hit;
        end
        bias_model = clip_add(bias_model, scaled <<< FEAT_FRAC, hit);
        clip |= hit;
      end
    end
    v.train_error = ERR_W'(e);
    v.saturated   = clip;
    return v;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_LEARNING_RATE) begin
      rate_model = int'(data[LR_W-1:0]);
    end else if (idx == REG_INPUTS_USED) begin
      count_model = int'(data[CNT_CFG_W-1:0]);
    end
  endfunction

  // Place a value in the low bits and random noise above it
  function automatic logic [CFG_DATA_W-1:0] with_noise(int value, int width);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom) & ~((CFG_DATA_W'(1) << width) - CFG_DATA_W'(1));
    return d | CFG_DATA_W'(value);
  endfunction

  // Alternate two values over the features, feature 0 gets the first
  function automatic logic [NUM_INPUTS-1:0][FEAT_BITS-1:0] mixed_features(
    logic [FEAT_BITS-1:0] a, logic [FEAT_BITS-1:0] b);
    return {(NUM_INPUTS/2){b, a}};
  endfunction

  function automatic void add_item(logic req, logic tgt,
                                   logic [NUM_INPUTS-1:0][FEAT_BITS-1:0] feats,
                                   logic typed, verdict_t want);
    stim_row_t r;
    r.kind          = ROW_ITEM;
    r.reg_index     = '0;
    r.reg_data      = '0;
    r.item.req_type = req;
    r.item.target   = tgt;
    r.item.feat     = feats;
    r.typed         = typed;
    r.want          = want;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r.kind      = ROW_REG;
    r.reg_index = idx;
    r.reg_data  = data;
    r.item      = '0;
    r.typed     = 1'b0;
    r.want      = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic item_word_t random_item();
    item_word_t w;
    int         k;
    w.req_type = 1'($urandom_range(1));
    w.target   = 1'($urandom_range(1));
    for (k = 0; k < NUM_INPUTS; k++) begin
      case ($urandom_range(7))
        0:       w.feat[k] = FEAT_MAX;
        1:       w.feat[k] = FEAT_MIN;
        2:       w.feat[k] = FEAT_ZERO;
        default: w.feat[k] = FEAT_BITS'($urandom);
      endcase
    end
    return w;
  endfunction

  // Pick feature signs that keep the sum near zero and a target that
  // disagrees, so each update grows the weights instead of undoing them
  function automatic item_word_t balanced_item();
    item_word_t w;
    longint     acc;
    longint     fill;
    logic       pick_min;
    int         k;
    w          = '0;
    w.req_type = REQ_TRAIN;
    acc        = longint'(bias_model) <<< FEAT_FRAC;
    for (k = 0; k < MAX_FEAT - 1; k++) begin
      if (weight_model[k] == 0) begin
        pick_min = 1'($urandom_range(1));
      end else begin
        pick_min = ((acc > 0) == (weight_model[k] > 0));
      end
      w.feat[k] = pick_min ? FEAT_MIN : FEAT_MAX;
      acc += longint'(weight_model[k]) * longint'($signed(w.feat[k]));
    end
    if (weight_model[MAX_FEAT-1] != 0) begin
      fill = -acc / longint'(weight_model[MAX_FEAT-1]);
      if (fill > longint'($signed(FEAT_MAX))) fill = longint'($signed(FEAT_MAX));
      if (fill < longint'($signed(FEAT_MIN))) fill = longint'($signed(FEAT_MIN));
    end else begin
      fill = longint'($signed(FEAT_BITS'($urandom)));
    end
    w.feat[MAX_FEAT-1] = FEAT_BITS'(fill);
    acc += longint'(weight_model[MAX_FEAT-1]) * fill;
    w.target = (acc < 0);
    return w;
  endfunction

  // Present one word, hold it until accepted, then record its verdict
  task automatic offer_item(input item_word_t w, input logic typed, input verdict_t want);
    verdict_t got;
    cfg_ch.valid <= 1'b0;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    item_ch.valid     <= 1'b1;
    item_ch.req_type  <= w.req_type;
    item_ch.target    <= w.target;
    item_ch.feature_0 <= w.feat[0];
    item_ch.feature_1 <= w.feat[1];
    item_ch.feature_2 <= w.feat[2];
    item_ch.feature_3 <= w.feat[3];
    item_ch.feature_4 <= w.feat[4];
    item_ch.feature_5 <= w.feat[5];
    item_ch.feature_6 <= w.feat[6];
    item_ch.feature_7 <= w.feat[7];
    do @(posedge clk_i); while (!item_ch.ready);
    got = classify_and_learn(w);
    pending_verdicts.push_back(typed ? want : got);
    items_sent++;
    if (w.req_type == REQ_TRAIN) trains_sent++;
  endtask

  // Hold a register word until accepted; the next item lowers valid
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    apply_register(idx, data);
    writes_done++;
  endtask

  // Drop the item valid and wait for every outstanding verdict
  task automatic await_results();
    item_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int rate,
                           input int count, input int n, input bit steer);
    int i;
    await_results();
    write_register(REG_LEARNING_RATE, with_noise(rate, LR_W));
    write_register(REG_INPUTS_USED, with_noise(count, CNT_CFG_W));
    write_register(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_INPUTS_USED + 1)),
                   CFG_DATA_W'($urandom));
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (i = 0; i < n; i++) begin
      if (!steer && $urandom_range(59) == 0) await_results();
      offer_item(steer ? balanced_item() : random_item(), 1'b0, '0);
    end
  endtask

  // Accept results with random stalls and check them in order
  initial begin : result_monitor
    verdict_t want;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_ch.valid && result_ch.ready) begin
        verdicts_seen++;
        if (result_ch.saturated === 1'b1) clips_seen++;
        if (pending_verdicts.size() == 0) begin
          $error("result word with no verdict waiting");
          fail_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (result_ch.prediction !== want.prediction) begin
            $error("prediction: expected %0d, got %0d", want.prediction, result_ch.prediction);
            fail_count++;
          end
          if (result_ch.train_error !== want.train_error) begin
            $error("train_error: expected %b, got %b", want.train_error, result_ch.train_error);
            fail_count++;
          end
          if (result_ch.saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, result_ch.saturated);
            fail_count++;
          end
        end
      end
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Bound the run in case the block stops answering
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int        i;
    int        k;
    stim_row_t r;
    rst_ni            = 1'b0;
    item_ch.valid     = 1'b0;
    item_ch.req_type  = 1'b0;
    item_ch.target    = 1'b0;
    item_ch.feature_0 = '0;
    item_ch.feature_1 = '0;
    item_ch.feature_2 = '0;
    item_ch.feature_3 = '0;
    item_ch.feature_4 = '0;
    item_ch.feature_5 = '0;
    item_ch.feature_6 = '0;
    item_ch.feature_7 = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    fail_count        = 0;
    items_sent        = 0;
    trains_sent       = 0;
    verdicts_seen     = 0;
    clips_seen        = 0;
    writes_done       = 0;
    for (k = 0; k < MAX_FEAT; k++) weight_model[k] = 0;
    bias_model  = 0;
    rate_model  = int'(LR_RESET);
    count_model = int'(IU_RESET);

    // Zero weights and bias: the sum is zero, so the first four words all predict 1
    add_item(REQ_PREDICT, 1'b1, {NUM_INPUTS{FEAT_MAX}}, 1'b1, '{1'b1, ERR_ZERO, 1'b0});
    add_item(REQ_PREDICT, 1'b0, {NUM_INPUTS{FEAT_MIN}}, 1'b1, '{1'b1, ERR_ZERO, 1'b0});
    add_item(REQ_TRAIN, 1'b1, mixed_features(FEAT_MAX, FEAT_MIN), 1'b1,
             '{1'b1, ERR_ZERO, 1'b0});
    add_item(REQ_TRAIN, 1'b0, mixed_features(FEAT_MAX, FEAT_MIN), 1'b1,
             '{1'b1, ERR_NEG, 1'b0});
    add_item(REQ_PREDICT, 1'b1, mixed_features(FEAT_MAX, FEAT_MIN), 1'b0, '0);
    add_item(REQ_TRAIN, 1'b1, mixed_features(FEAT_MIN, FEAT_MAX), 1'b0, '0);
    add_item(REQ_TRAIN, 1'b0, mixed_features(16'h1000, 16'hF000), 1'b0, '0);
    // Bias alone
    add_reg(REG_INPUTS_USED, CFG_DATA_W'(0));
    add_item(REQ_TRAIN, 1'b1, {NUM_INPUTS{FEAT_MAX}}, 1'b0, '0);
    add_item(REQ_TRAIN, 1'b0, {NUM_INPUTS{FEAT_MIN}}, 1'b0, '0);
    add_item(REQ_PREDICT, 1'b0, {NUM_INPUTS{FEAT_MAX}}, 1'b0, '0);
    // Count above the limit clamps to all features; top rate, noisy upper bits
    add_reg(REG_INPUTS_USED, {CFG_DATA_W{1'b1}});
    add_reg(REG_LEARNING_RATE, {CFG_DATA_W{1'b1}});
    add_item(REQ_TRAIN, 1'b0, {NUM_INPUTS{FEAT_MAX}}, 1'b0, '0);
    add_item(REQ_TRAIN, 1'b1, {NUM_INPUTS{FEAT_MAX}}, 1'b0, '0);
    add_item(REQ_TRAIN, 1'b1, {NUM_INPUTS{FEAT_MIN}}, 1'b0, '0);
    add_item(REQ_TRAIN, 1'b0, {NUM_INPUTS{FEAT_MIN}}, 1'b0, '0);
    // Writes outside the register list change nothing
    add_reg(CFG_IDX_W'(REG_INPUTS_USED + 1), CFG_DATA_W'(0));
    add_reg({CFG_IDX_W{1'b1}}, {CFG_DATA_W{1'b1}});
    add_item(REQ_PREDICT, 1'b1, mixed_features(FEAT_MAX, FEAT_ZERO), 1'b0, '0);
    // Zero rate: errors reported, weights frozen
    add_reg(REG_LEARNING_RATE, CFG_DATA_W'(0));
    add_item(REQ_TRAIN, 1'b0, {NUM_INPUTS{FEAT_MAX}}, 1'b0, '0);
    add_item(REQ_TRAIN, 1'b1, {NUM_INPUTS{FEAT_MAX}}, 1'b0, '0);
    add_item(REQ_PREDICT, 1'b0, {NUM_INPUTS{FEAT_MAX}}, 1'b0, '0);
    add_reg(REG_INPUTS_USED, CFG_DATA_W'(MAX_FEAT + 1));
    add_reg(REG_LEARNING_RATE, CFG_DATA_W'(1));
    add_item(REQ_TRAIN, 1'b0, mixed_features(FEAT_MIN, FEAT_MAX), 1'b0, '0);
    add_reg(REG_INPUTS_USED, CFG_DATA_W'(1));
    add_item(REQ_TRAIN, 1'b1, mixed_features(FEAT_MIN, FEAT_MAX), 1'b0, '0);
    add_item(REQ_TRAIN, 1'b0, {NUM_INPUTS{FEAT_ZERO}}, 1'b0, '0);
    add_reg(REG_INPUTS_USED, CFG_DATA_W'(MAX_FEAT));
    add_item(REQ_TRAIN, 1'b1, mixed_features(16'h0001, 16'hFFFF), 1'b0, '0);

    // Hold reset, then release it on a clock edge
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table with light idling on both sides
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    for (i = 0; i < directed_rows.size(); i++) begin
      r = directed_rows[i];
      if (r.kind == ROW_REG) begin
        await_results();
        write_register(r.reg_index, r.reg_data);
      end else begin
        offer_item(r.item, r.typed, r.want);
      end
    end

    // Random phases: no idling, sender idle, weight drive, receiver stall, both
    run_phase(0, 0, (1 << LR_W) - 1, (1 << CNT_CFG_W) - 1, 280, 1'b0);
    run_phase(72, 0, $urandom_range((1 << LR_W) - 1), $urandom_range(MAX_FEAT - 1, 1),
              280, 1'b0);
    run_phase(0, 0, (1 << LR_W) - 1, MAX_FEAT, 400, 1'b1);
    run_phase(0, 72, 1, MAX_FEAT, 280, 1'b0);
    run_phase(8, 8, $urandom_range((1 << LR_W) - 1), $urandom_range((1 << CNT_CFG_W) - 1),
              280, 1'b0);

    // Drain with a bound, then let stray words show up
    item_ch.valid <= 1'b0;
    k = 0;
    while (pending_verdicts.size() != 0 && k < 5000) begin
      @(posedge clk_i);
      k++;
    end
    repeat (40) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      $error("%0d verdicts never arrived", pending_verdicts.size());
      fail_count++;
    end

    $display("Covered %0d words (%0d train) and %0d results, %0d of them clipped,",
             items_sent, trains_sent, verdicts_seen, clips_seen);
    $display("with %0d register writes across five idling phases.", writes_done);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
